// ===== hw/rtl/inverted_page_table_lookup_insert_unit_defines.svh =====
// assertion macros for the lookup and insert unit checker
`ifndef INVERTED_PAGE_TABLE_LOOKUP_INSERT_UNIT_DEFINES_SVH
`define INVERTED_PAGE_TABLE_LOOKUP_INSERT_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define IPTLI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define IPTLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/iptli_pkg.sv =====
// shared types and constants of the inverted page table lookup and insert unit
package iptli_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_PLACED = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // configuration register map
  localparam logic       REG_FRAMES_IN_USE = 1'b0;
  localparam int unsigned FIU_W            = 7;
  localparam logic [6:0] FIU_RESET         = 7'd64;

  // request fields broadcast to every cell
  typedef struct packed {
    logic [19:0] page_number;
    logic [7:0]  process_id;
    logic        is_write;
    logic [31:0] time_stamp;
    logic [15:0] page_offset;
  } req_t;

  // search token flags handed from cell to cell
  typedef struct packed {
    logic live;
    logic hit;
    logic free_found;
  } tok_t;

endpackage

// ===== hw/rtl/iptli_cell.sv =====
// one frame table entry with its stage of the search token chain
module iptli_cell #(
  parameter int unsigned Frames = 64,
  parameter int unsigned Index  = 0,
  localparam int unsigned IdxW  = $clog2(Frames),
  localparam int unsigned CntW  = ($clog2(Frames + 1) > 7) ? $clog2(Frames + 1) : 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iptli_pkg::req_t     req_i,
  input  logic [CntW-1:0]     size_i,
  input  logic                place_i,
  input  logic [IdxW-1:0]     place_idx_i,
  input  iptli_pkg::tok_t     tok_i,
  input  logic [IdxW-1:0]     hit_idx_i,
  input  logic [IdxW-1:0]     free_idx_i,
  output iptli_pkg::tok_t     tok_o,
  output logic [IdxW-1:0]     hit_idx_o,
  output logic [IdxW-1:0]     free_idx_o
);
  import iptli_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic            valid_q;
  logic [19:0]     page_q;
  logic [7:0]      process_q;
  logic            modified_q;
  logic [31:0]     last_use_q;
  logic [15:0]     offset_q;
  logic            active;
  logic            match;
  logic            hit_here;
  logic            free_here;
  logic            place_here;
  tok_t            tok_d, tok_q;
  logic [IdxW-1:0] hit_idx_d, hit_idx_q;
  logic [IdxW-1:0] free_idx_d, free_idx_q;

  // compare the passing request against this entry
  always_comb begin
    active     = CntW'(Index) < size_i;
    match      = valid_q && (page_q == req_i.page_number) && (process_q == req_i.process_id);
    hit_here   = tok_i.live && !tok_i.hit && active && match;
    free_here  = tok_i.live && !tok_i.hit && !tok_i.free_found && active && !valid_q;
    place_here = place_i && (place_idx_i == MyIdx);
    tok_d.live       = tok_i.live;
    tok_d.hit        = tok_i.hit || hit_here;
    tok_d.free_found = tok_i.free_found || free_here;
    hit_idx_d        = hit_here ? MyIdx : hit_idx_i;
    free_idx_d       = free_here ? MyIdx : free_idx_i;
  end

  // token stage and valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (place_here) begin
        valid_q <= 1'b1;
      end
    end
  end

  // token indexes and entry contents
  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (place_here) begin
      page_q     <= req_i.page_number;
      process_q  <= req_i.process_id;
      modified_q <= req_i.is_write;
      last_use_q <= req_i.time_stamp;
      offset_q   <= req_i.page_offset;
    end else if (hit_here) begin
      modified_q <= modified_q | req_i.is_write;
      last_use_q <= req_i.time_stamp;
      offset_q   <= req_i.page_offset;
    end
  end

  assign tok_o      = tok_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

// ===== hw/rtl/inverted_page_table_lookup_insert_unit.sv =====
// the request is latched, then its search token walks the chain of frame cells, one cell per cycle,
// and the result is registered in the finish state once the output is not stalled
// one request in flight at a time: a new request is stalled until the previous result is registered
// reset clears every frame valid bit and the used count and sets frames_in_use to 64
// reset takes effect at once, no clearing pass follows
module inverted_page_table_lookup_insert_unit #(
  parameter int unsigned FRAMES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] page_number_i,
  input  logic [7:0]  process_id_i,
  input  logic        is_write_i,
  input  logic [31:0] time_stamp_i,
  input  logic [15:0] page_offset_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  frame_index_o,
  output logic [6:0]  frames_used_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import iptli_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAMES);
  localparam int unsigned CntW = ($clog2(FRAMES + 1) > 7) ? $clog2(FRAMES + 1) : 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_e;

  state_e          state_q;
  logic            launch_q;
  req_t            req_q;
  logic [FIU_W-1:0] fiu_q;
  logic [CntW-1:0] fiu_ext;
  logic [CntW-1:0] size;
  logic [CntW-1:0] used_q;
  logic [CntW-1:0] used_d;
  logic            fin_hit_q;
  logic            fin_free_q;
  logic [IdxW-1:0] fin_hit_idx_q;
  logic [IdxW-1:0] fin_free_idx_q;
  logic            out_valid_q;
  status_e         status_q;
  logic [5:0]      frame_index_q;
  logic [6:0]      frames_used_q;
  logic            accept;
  logic            out_free;
  logic            fin_go;
  logic            place_ok;
  logic            place_en;
  status_e         fin_status;
  logic [IdxW-1:0] fin_idx;
  logic            cfg_wr;

  tok_t            tok      [FRAMES+1];
  logic [IdxW-1:0] hit_idx  [FRAMES+1];
  logic [IdxW-1:0] free_idx [FRAMES+1];

  // configuration register
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? 32'(fiu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= FIU_RESET;
    end else if (cfg_wr && (paddr[2] == REG_FRAMES_IN_USE)) begin
      fiu_q <= pwdata[FIU_W-1:0];
    end
  end

  // active table size saturates at the number of cells
  always_comb begin
    fiu_ext = CntW'(fiu_q);
    size    = (fiu_ext > CntW'(FRAMES)) ? CntW'(FRAMES) : fiu_ext;
  end

  // handshake and placement decision
  always_comb begin
    accept   = in_valid_i && (state_q == S_IDLE);
    out_free = !out_valid_q || !out_stall_i;
    fin_go   = (state_q == S_FINISH) && out_free;
    place_ok = !fin_hit_q && fin_free_q && (used_q < size);
    place_en = fin_go && place_ok;
    used_d   = used_q + CntW'(place_ok);
    if (fin_hit_q) begin
      fin_status = ST_HIT;
      fin_idx    = fin_hit_idx_q;
    end else if (place_ok) begin
      fin_status = ST_PLACED;
      fin_idx    = fin_free_idx_q;
    end else begin
      fin_status = ST_FULL;
      fin_idx    = '0;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign frame_index_o = frame_index_q;
  assign frames_used_o = frames_used_q;

  // sequencer, used count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      launch_q <= accept;
      // result valid: set on finish, cleared once taken
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q.page_number <= page_number_i;
            req_q.process_id  <= process_id_i;
            req_q.is_write    <= is_write_i;
            req_q.time_stamp  <= time_stamp_i;
            req_q.page_offset <= page_offset_i;
            state_q           <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (tok[FRAMES].live) begin
            fin_hit_q      <= tok[FRAMES].hit;
            fin_free_q     <= tok[FRAMES].free_found;
            fin_hit_idx_q  <= hit_idx[FRAMES];
            fin_free_idx_q <= free_idx[FRAMES];
            state_q        <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            status_q      <= fin_status;
            frame_index_q <= 6'(fin_idx);
            frames_used_q <= 7'(used_d);
            used_q        <= used_d;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // token enters the chain the cycle after the request is latched
  assign tok[0].live       = launch_q;
  assign tok[0].hit        = 1'b0;
  assign tok[0].free_found = 1'b0;
  assign hit_idx[0]        = '0;
  assign free_idx[0]       = '0;

  // chain of frame cells
  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    iptli_cell #(
      .Frames (FRAMES),
      .Index  (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .req_i       (req_q),
      .size_i      (size),
      .place_i     (place_en),
      .place_idx_i (fin_free_idx_q),
      .tok_i       (tok[k]),
      .hit_idx_i   (hit_idx[k]),
      .free_idx_i  (free_idx[k]),
      .tok_o       (tok[k+1]),
      .hit_idx_o   (hit_idx[k+1]),
      .free_idx_o  (free_idx[k+1])
    );
  end

endmodule

// ===== hw/rtl/iptli_checker.sv =====
// port-level checker for the lookup and insert unit and its bind
`include "inverted_page_table_lookup_insert_unit_defines.svh"

module iptli_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [5:0]  frame_index_o,
  input logic [6:0]  frames_used_o
);
  import iptli_pkg::*;

  // a stalled result holds its payload
  `IPTLI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(frame_index_o) && $stable(frames_used_o), "result changed while stalled")

  // one request in flight: an accepted request stalls the next one
  `IPTLI_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "second request taken while busy")

  // a full result reports frame zero
  `IPTLI_ASSERT_IMPL(a_full_index, out_valid_o && (status_o == ST_FULL), frame_index_o == 6'd0, "full result with nonzero frame index")

  // a placement leaves at least one frame in use
  `IPTLI_ASSERT_IMPL(a_placed_used, out_valid_o && (status_o == ST_PLACED), frames_used_o != 7'd0, "placement with zero frames used")

endmodule

bind inverted_page_table_lookup_insert_unit iptli_checker u_iptli_checker (.*);
